// File: src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// types, codes and sizes shared by the double-ended queue files
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    localparam int DEQ_DEPTH = 16;
    localparam int AW        = $clog2(DEQ_DEPTH);
    localparam int CW        = $clog2(DEQ_DEPTH + 1);

    localparam logic [2:0] ACT_QUERY      = 3'd0;
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [2:0] ACT_POP_BACK   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        [2:0]  action;
        logic signed [31:0] push_value;
    } t_deq_req;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic        [1:0]  status;
        logic        [4:0]  entry_count;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
    } t_deq_rsp;

endpackage

`default_nettype wire

// File: src/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// word store of the queue: one write port, one read port, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [deq_pkg::AW-1:0]   i_waddr,
    input  wire logic [31:0]              i_wdata,
    input  wire logic [deq_pkg::AW-1:0]   i_raddr,
    output logic      [31:0]              o_rdata
);
    import deq_pkg::*;

    logic [31:0] r_mem [DEQ_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// result: registered; a pop that leaves two or more words goes through S_READ,
// where the new end word is read from the word store, before its result
// throughput: one request per cycle while the result is taken, none in S_READ
// reset: synchronous, clears count, pointers and pending result
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire deq_pkg::t_deq_req i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output deq_pkg::t_deq_rsp      o_out_data
);
    import deq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state       r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back, n_back;
    logic [CW-1:0] r_count, n_count;
    logic [31:0]  r_front_word, n_front_word;
    logic [31:0]  r_back_word, n_back_word;
    logic         r_rd_front, n_rd_front;
    logic         r_out_valid, n_out_valid;
    t_deq_rsp     r_out, n_out;

    logic          accept;
    logic          full, empty;
    logic [AW-1:0] front_prev, front_next, back_next, back_prev, back_prev2;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   rdata;

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEQ_DEPTH - 1) : i - 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
        return (i == AW'(DEQ_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign full       = (r_count == CW'(DEQ_DEPTH));
    assign empty      = (r_count == '0);
    assign front_prev = slot_prev(r_front);
    assign front_next = slot_next(r_front);
    assign back_next  = slot_next(r_back);
    assign back_prev  = slot_prev(r_back);
    assign back_prev2 = slot_prev(back_prev);

    deq_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_in_data.push_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_back       = r_back;
        n_count      = r_count;
        n_front_word = r_front_word;
        n_back_word  = r_back_word;
        n_rd_front   = r_rd_front;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        we           = 1'b0;
        waddr        = front_prev;
        raddr        = front_next;

        if (r_state == S_READ) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            if (r_rd_front) begin
                n_front_word      = rdata;
                n_out.front_value = rdata;
            end else begin
                n_back_word      = rdata;
                n_out.back_value = rdata;
            end
        end else if (accept) begin
            n_out_valid        = 1'b1;
            n_out.popped_value = '0;
            n_out.status       = ST_OK;
            case (i_in_data.action)
                ACT_PUSH_FRONT: begin
                    if (full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        we           = 1'b1;
                        waddr        = front_prev;
                        n_front      = front_prev;
                        n_count      = r_count + 1'b1;
                        n_front_word = i_in_data.push_value;
                        if (empty) begin
                            n_back_word = i_in_data.push_value;
                        end
                    end
                end
                ACT_PUSH_BACK: begin
                    if (full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        we          = 1'b1;
                        waddr       = r_back;
                        n_back      = back_next;
                        n_count     = r_count + 1'b1;
                        n_back_word = i_in_data.push_value;
                        if (empty) begin
                            n_front_word = i_in_data.push_value;
                        end
                    end
                end
                ACT_POP_FRONT: begin
                    if (empty) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_out.popped_value = r_front_word;
                        n_front            = front_next;
                        n_count            = r_count - 1'b1;
                        raddr              = front_next;
                        if (r_count == CW'(2)) begin
                            n_front_word = r_back_word;
                        end else if (r_count > CW'(2)) begin
                            n_state     = S_READ;
                            n_rd_front  = 1'b1;
                            n_out_valid = 1'b0;
                        end
                    end
                end
                ACT_POP_BACK: begin
                    if (empty) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_out.popped_value = r_back_word;
                        n_back             = back_prev;
                        n_count            = r_count - 1'b1;
                        raddr              = back_prev2;
                        if (r_count == CW'(2)) begin
                            n_back_word = r_front_word;
                        end else if (r_count > CW'(2)) begin
                            n_state     = S_READ;
                            n_rd_front  = 1'b0;
                            n_out_valid = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
            n_out.entry_count = 5'(n_count);
            n_out.front_value = (n_count == '0) ? '0 : n_front_word;
            n_out.back_value  = (n_count == '0) ? '0 : n_back_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_back      <= n_back;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_front_word <= n_front_word;
        r_back_word  <= n_back_word;
        r_rd_front   <= n_rd_front;
        r_out        <= n_out;
    end

endmodule

`default_nettype wire

// File: src/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// port-level checks of the double-ended queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              o_in_ready,
    input  wire deq_pkg::t_deq_req i_in_data,
    input  wire logic              o_out_valid,
    input  wire logic              i_out_ready,
    input  wire deq_pkg::t_deq_rsp o_out_data
);
    import deq_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_data)))
        else $error("waiting request changed");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_FULL)
            |-> (o_out_data.entry_count == 5'(DEQ_DEPTH)))
        else $error("full status with room left");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.entry_count == 5'd0)
            |-> (o_out_data.front_value == '0 && o_out_data.back_value == '0
                 && o_out_data.status != ST_FULL))
        else $error("empty queue shows words");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// File: tb/double_ended_queue_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_test
// Self-checking bench for the bounded double-ended queue. A scoreboard keeps
// its own circular buffer and works out the result of every accepted request:
// the popped word, the status, the count and both end words. Each result is
// then compared with the oldest expectation. A short directed run covers
// empty pops, extreme words and the unused action codes. Random traffic
// follows, with push-heavy, pop-heavy and mixed phases, so the queue runs
// full and empty many times. Random gaps occur on both sides, and long
// output stalls back the block up into its request port.
// ----------------------------------------------------------------------------

module double_ended_queue_unit_test;

    import deq_pkg::*;

    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SEGMENTS    = 15;
    localparam int         SEG_ITEMS   = 60;

    class deque_scoreboard;
        logic signed [31:0] slot_words [DEQ_DEPTH];
        int                 head_slot;
        int                 tail_slot;
        int                 word_count;
        t_deq_rsp           expected_rsps [$];
        int                 mismatches;

        function new();
            head_slot  = 0;
            tail_slot  = 0;
            word_count = 0;
            mismatches = 0;
        endfunction

        function void note_request(t_deq_req req);
            t_deq_rsp rsp;
            rsp = '0;
            rsp.status = ST_OK;
            case (req.action)
                ACT_PUSH_FRONT: begin
                    if (word_count == DEQ_DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        head_slot = (head_slot + DEQ_DEPTH - 1) % DEQ_DEPTH;
                        slot_words[head_slot] = req.push_value;
                        word_count++;
                    end
                end
                ACT_PUSH_BACK: begin
                    if (word_count == DEQ_DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        slot_words[tail_slot] = req.push_value;
                        tail_slot = (tail_slot + 1) % DEQ_DEPTH;
                        word_count++;
                    end
                end
                ACT_POP_FRONT: begin
                    if (word_count == 0) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        rsp.popped_value = slot_words[head_slot];
                        head_slot = (head_slot + 1) % DEQ_DEPTH;
                        word_count--;
                    end
                end
                ACT_POP_BACK: begin
                    if (word_count == 0) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        tail_slot = (tail_slot + DEQ_DEPTH - 1) % DEQ_DEPTH;
                        rsp.popped_value = slot_words[tail_slot];
                        word_count--;
                    end
                end
                default: begin
                end
            endcase
            rsp.entry_count = 5'(word_count);
            if (word_count != 0) begin
                rsp.front_value = slot_words[head_slot];
                rsp.back_value  = slot_words[(tail_slot + DEQ_DEPTH - 1) % DEQ_DEPTH];
            end
            expected_rsps.push_back(rsp);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_deq_rsp got);
            t_deq_rsp want;
            if (expected_rsps.size() == 0) begin
                $error("result with no request pending: %h", got);
                mismatches++;
            end else begin
                want = expected_rsps.pop_front();
                compare_field("popped_value", want.popped_value, got.popped_value);
                compare_field("status", want.status, got.status);
                compare_field("entry_count", want.entry_count, got.entry_count);
                compare_field("front_value", want.front_value, got.front_value);
                compare_field("back_value", want.back_value, got.back_value);
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n   = 1'b0;
    logic     in_valid  = 1'b0;
    t_deq_req in_data   = '0;
    logic     out_ready = 1'b0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_deq_rsp o_out_data;

    deque_scoreboard deque_sb;
    bit              sender_idle = 1'b0;
    bit              rcv_idle    = 1'b0;
    int              cycle_count = 0;

    double_ended_queue_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("double_ended_queue_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_action(int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct) begin
            return ($urandom_range(0, 1) != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        end else if (roll < 94) begin
            return ($urandom_range(0, 1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK;
        end else if (roll < 97) begin
            return ACT_QUERY;
        end else begin
            case ($urandom_range(0, 2))
                0: return ACT_SPARE_A;
                1: return ACT_SPARE_B;
                default: return ACT_SPARE_C;
            endcase
        end
    endfunction

    task automatic send_request(input logic [2:0] action, input logic [31:0] word);
        int       gap;
        t_deq_req req;
        req.action     = action;
        req.push_value = word;
        gap = sender_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        deque_sb.note_request(req);
    endtask

    // result side: random stalls, plus two long hold-offs to back up the block
    initial begin
        int       stall;
        int       seen;
        t_deq_rsp rsp;
        seen = 0;
        @(posedge i_rst_n);
        forever begin
            if (seen % 40 == 0) begin
                rcv_idle = ($urandom_range(0, 2) != 0);
            end
            if (seen == 150 || seen == 600) begin
                stall = 300;
            end else begin
                stall = rcv_idle ? $urandom_range(0, 19) : 0;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(negedge i_clk);
            while (!o_out_valid) @(negedge i_clk);
            rsp = o_out_data;
            @(posedge i_clk);
            deque_sb.check_result(rsp);
            seen++;
        end
    end

    initial begin
        int push_pct;
        deque_sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pops, extreme words, unused codes, single-word pops
        send_request(ACT_QUERY, 32'h0000_0000);
        send_request(ACT_POP_FRONT, 32'h1234_5678);
        send_request(ACT_POP_BACK, 32'hffff_ffff);
        send_request(ACT_PUSH_BACK, 32'h7fff_ffff);
        send_request(ACT_PUSH_FRONT, 32'h8000_0000);
        send_request(ACT_SPARE_A, 32'hffff_ffff);
        send_request(ACT_SPARE_B, 32'h0000_0000);
        send_request(ACT_SPARE_C, 32'h5555_5555);
        send_request(ACT_POP_FRONT, 32'haaaa_aaaa);
        send_request(ACT_POP_BACK, 32'h5555_5555);
        send_request(ACT_PUSH_FRONT, 32'hffff_ffff);
        send_request(ACT_POP_BACK, 32'h0000_0000);
        send_request(ACT_PUSH_BACK, 32'h0000_0000);
        send_request(ACT_POP_FRONT, 32'h0000_0000);
        send_request(ACT_PUSH_BACK, 32'hdead_beef);
        send_request(ACT_PUSH_FRONT, 32'h0bad_cafe);
        send_request(ACT_QUERY, 32'haaaa_aaaa);
        send_request(ACT_POP_BACK, 32'h0000_0000);
        send_request(ACT_POP_BACK, 32'h0000_0000);
        send_request(ACT_POP_FRONT, 32'h0000_0000);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            sender_idle = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < SEG_ITEMS; k++) begin
                send_request(pick_action(push_pct), pick_word());
            end
        end

        in_valid <= 1'b0;
        while (deque_sb.expected_rsps.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (deque_sb.mismatches == 0) begin
            $display("double_ended_queue_unit: match");
        end else begin
            $display("double_ended_queue_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
src/deq_pkg.sv
src/deq_ram.sv
src/double_ended_queue_unit.sv
src/deq_checker.sv
tb/double_ended_queue_unit_test.sv
